>>> rtl/lam_pkg.sv
package lam_pkg;

	// Fixed point one in Q16.16.
	localparam logic [31:0] FX_ONE = 32'h0001_0000;

	// A difference of two 32-bit values needs 33 bits. One more bit keeps the
	// magnitude of the most negative difference in range.
	localparam int VEC_W  = 34;
	// A normalized component lies in [-1.0, 1.0] in Q16.16.
	localparam int UNIT_W = 18;
	// Width of the scaled magnitudes: top set bit at bit 30.
	localparam int SMAG_W = 31;
	// The integer square root of a 64-bit sum resolves one result bit per step.
	localparam int SQ_STEPS  = 32;
	// A normalized quotient is at most 65536, so 17 quotient bits.
	localparam int DIV_STEPS = 17;

	// Latencies of the pipelined units, in clock cycles.
	localparam int NORM_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;
	localparam int PROJ_LAT  = 2;
	localparam int CROSS_LAT = 2;

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [UNIT_W-1:0] unit_t;

	typedef struct packed {
		logic valid;
		logic ok;
	} norm_ctl_t;

	// Round to nearest, ties away from zero, then drop 16 fraction bits.
	function automatic logic signed [47:0] rnd_q16(input logic signed [47:0] v);
		logic [47:0] mag;
		logic [47:0] r;
		mag = v[47] ? 48'(-v) : 48'(v);
		r = (mag + 48'h8000) >> 16;
		return v[47] ? -signed'(r) : signed'(r);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [47:0] v);
		logic [31:0] r;
		if (v > 48'sh0000_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < -48'sh0000_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/lam_delay.sv
module lam_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] dly_s [DEPTH];

	always_ff @(posedge clk) begin
		dly_s[0] <= din;
		for (int k = 1; k < DEPTH; k++) begin
			dly_s[k] <= dly_s[k-1];
		end
	end

	assign dout = dly_s[DEPTH-1];

endmodule

>>> rtl/lam_norm.sv
module lam_norm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lam_pkg::vec_t      in_vec [3],
	output lam_pkg::norm_ctl_t out_ctl,
	output lam_pkg::unit_t     out_vec [3]
);

	localparam int MW  = lam_pkg::VEC_W - 1;
	localparam int SW  = lam_pkg::SMAG_W;
	localparam int SQ  = lam_pkg::SQ_STEPS;
	localparam int DQ  = lam_pkg::DIV_STEPS;
	localparam int LAT = lam_pkg::NORM_LAT;

	logic [LAT:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	// Magnitudes and signs.
	logic [MW-1:0] mag_s1 [3];
	logic [2:0]    neg_s1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= in_vec[i][lam_pkg::VEC_W-1];
			mag_s1[i] <= in_vec[i][lam_pkg::VEC_W-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
		end
	end

	// Position of the top set bit over all three magnitudes.
	logic [MW-1:0] orv;
	logic [5:0]    top_c;
	logic [MW-1:0] mag_s2 [3];
	logic [2:0]    neg_s2;
	logic [5:0]    top_s2;
	logic          zero_s2;

	always_comb begin
		orv = mag_s1[0] | mag_s1[1] | mag_s1[2];
		top_c = '0;
		for (int b = 0; b < MW; b++) begin
			if (orv[b]) begin
				top_c = 6'(b);
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
		top_s2  <= top_c;
		zero_s2 <= (orv == '0);
	end

	// Common shift that puts the top bit at bit 30.
	logic [SW-1:0] smag_s3 [3];
	logic [2:0]    neg_s3;
	logic          zero_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (top_s2 > 6'(SW - 1)) begin
				smag_s3[i] <= SW'(mag_s2[i] >> (top_s2 - 6'(SW - 1)));
			end else begin
				smag_s3[i] <= SW'(mag_s2[i] << (6'(SW - 1) - top_s2));
			end
		end
		neg_s3  <= neg_s2;
		zero_s3 <= zero_s2;
	end

	logic [2*SW-1:0] sqr_s4 [3];
	logic [SW-1:0]   smag_s4 [3];
	logic [2:0]      neg_s4;
	logic            zero_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sqr_s4[i] <= smag_s3[i] * smag_s3[i];
		end
		smag_s4 <= smag_s3;
		neg_s4  <= neg_s3;
		zero_s4 <= zero_s3;
	end

	// Square root pipeline, one result bit per stage. Entry 0 is the sum.
	logic [63:0]   sq_num_s  [0:SQ];
	logic [63:0]   sq_res_s  [0:SQ];
	logic [SW-1:0] sq_mag_s  [0:SQ][3];
	logic [2:0]    sq_neg_s  [0:SQ];
	logic          sq_zero_s [0:SQ];

	always_ff @(posedge clk) begin
		sq_num_s[0]  <= 64'(sqr_s4[0]) + 64'(sqr_s4[1]) + 64'(sqr_s4[2]);
		sq_res_s[0]  <= '0;
		sq_mag_s[0]  <= smag_s4;
		sq_neg_s[0]  <= neg_s4;
		sq_zero_s[0] <= zero_s4;
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
		logic [63:0] trial;
		logic        take;

		always_comb begin
			trial = sq_res_s[k] + BITV;
			take  = (sq_num_s[k] >= trial);
		end

		always_ff @(posedge clk) begin
			sq_num_s[k+1]  <= take ? (sq_num_s[k] - trial) : sq_num_s[k];
			sq_res_s[k+1]  <= take ? ((sq_res_s[k] >> 1) + BITV) : (sq_res_s[k] >> 1);
			sq_mag_s[k+1]  <= sq_mag_s[k];
			sq_neg_s[k+1]  <= sq_neg_s[k];
			sq_zero_s[k+1] <= sq_zero_s[k];
		end
	end

	// Restoring division of (m * 65536 + len / 2) by len. The quotient fits
	// in DQ bits, so the upper numerator bits start below the divisor.
	logic [32:0]   dv_rem_s  [0:DQ][3];
	logic [DQ-1:0] dv_low_s  [0:DQ][3];
	logic [DQ-1:0] dv_q_s    [0:DQ][3];
	logic [31:0]   dv_len_s  [0:DQ];
	logic [2:0]    dv_neg_s  [0:DQ];
	logic          dv_zero_s [0:DQ];

	logic [31:0] len_c;
	logic [47:0] num_c [3];

	always_comb begin
		len_c = sq_res_s[SQ][31:0];
		for (int i = 0; i < 3; i++) begin
			num_c[i] = {1'b0, sq_mag_s[SQ][i], 16'h0000} + 48'(len_c >> 1);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= 33'(num_c[i][47:DQ]);
			dv_low_s[0][i] <= num_c[i][DQ-1:0];
			dv_q_s[0][i]   <= '0;
		end
		dv_len_s[0]  <= len_c;
		dv_neg_s[0]  <= sq_neg_s[SQ];
		dv_zero_s[0] <= sq_zero_s[SQ];
	end

	for (genvar j = 0; j < DQ; j++) begin : g_div
		logic [33:0] r2 [3];
		logic [2:0]  ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r2[i] = {dv_rem_s[j][i], dv_low_s[j][i][DQ-1]};
				ge[i] = (r2[i] >= {2'b00, dv_len_s[j]});
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[j+1][i] <= ge[i] ? 33'(r2[i] - {2'b00, dv_len_s[j]}) : 33'(r2[i]);
				dv_low_s[j+1][i] <= dv_low_s[j][i] << 1;
				dv_q_s[j+1][i]   <= {dv_q_s[j][i][DQ-2:0], ge[i]};
			end
			dv_len_s[j+1]  <= dv_len_s[j];
			dv_neg_s[j+1]  <= dv_neg_s[j];
			dv_zero_s[j+1] <= dv_zero_s[j];
		end
	end

	// Sign, and zero output for a zero vector.
	lam_pkg::unit_t res_s [3];
	logic           ok_s;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[DQ]) begin
				res_s[i] <= '0;
			end else if (dv_neg_s[DQ][i]) begin
				res_s[i] <= -signed'({1'b0, dv_q_s[DQ][i]});
			end else begin
				res_s[i] <= signed'({1'b0, dv_q_s[DQ][i]});
			end
		end
		ok_s <= !dv_zero_s[DQ];
	end

	assign out_ctl.valid = vld_s[LAT];
	assign out_ctl.ok    = ok_s;
	assign out_vec       = res_s;

endmodule

>>> rtl/lam_proj.sv
module lam_proj (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  lam_pkg::unit_t fwd [3],
	output logic           out_valid,
	output lam_pkg::vec_t  pre [3]
);

	logic [1:0] vld_s;
	logic signed [2*lam_pkg::UNIT_W-1:0] prod_s1 [3];
	lam_pkg::vec_t pre_s2 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[0], in_valid};
		end
	end

	// Up minus its projection on forward; up . forward is forward.y.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= fwd[i] * fwd[1];
		end
		pre_s2[0] <= lam_pkg::VEC_W'(-lam_pkg::rnd_q16(48'(prod_s1[0])));
		pre_s2[1] <= lam_pkg::VEC_W'(signed'(48'(lam_pkg::FX_ONE))
			- lam_pkg::rnd_q16(48'(prod_s1[1])));
		pre_s2[2] <= lam_pkg::VEC_W'(-lam_pkg::rnd_q16(48'(prod_s1[2])));
	end

	assign out_valid = vld_s[1];
	assign pre       = pre_s2;

endmodule

>>> rtl/lam_cross.sv
module lam_cross (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_degen,
	input  lam_pkg::unit_t nup [3],
	input  lam_pkg::unit_t fwd [3],
	output logic           out_valid,
	output logic           out_degen,
	output logic [31:0]    rgt [3],
	output lam_pkg::unit_t nup_out [3],
	output lam_pkg::unit_t fwd_out [3]
);

	localparam int PW = 2 * lam_pkg::UNIT_W;

	logic [1:0] vld_s;
	logic signed [PW-1:0] pa_s1 [3];
	logic signed [PW-1:0] pb_s1 [3];
	lam_pkg::unit_t nup_s1 [3];
	lam_pkg::unit_t fwd_s1 [3];
	logic           degen_s1;
	logic [31:0]    rgt_s2 [3];
	lam_pkg::unit_t nup_s2 [3];
	lam_pkg::unit_t fwd_s2 [3];
	logic           degen_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		pa_s1[0] <= nup[1] * fwd[2];
		pb_s1[0] <= nup[2] * fwd[1];
		pa_s1[1] <= nup[2] * fwd[0];
		pb_s1[1] <= nup[0] * fwd[2];
		pa_s1[2] <= nup[0] * fwd[1];
		pb_s1[2] <= nup[1] * fwd[0];
		nup_s1   <= nup;
		fwd_s1   <= fwd;
		degen_s1 <= in_degen;
		for (int i = 0; i < 3; i++) begin
			rgt_s2[i] <= lam_pkg::sat32(lam_pkg::rnd_q16(48'(pa_s1[i]) - 48'(pb_s1[i])));
		end
		nup_s2   <= nup_s1;
		fwd_s2   <= fwd_s1;
		degen_s2 <= degen_s1;
	end

	assign out_valid = vld_s[1];
	assign out_degen = degen_s2;
	assign rgt       = rgt_s2;
	assign nup_out   = nup_s2;
	assign fwd_out   = fwd_s2;

endmodule

>>> rtl/look_at_matrix_builder.sv
// Look-at matrix builder. The first row appears once an item has passed the first stage,
// both normalizers, the projection, the cross product and the row sequencer, and the four
// rows follow on consecutive cycles. A new item is taken only while busy is low; busy
// rises after each transfer, as the single result channel carries four rows per item.
// Reset (arst_n low, asynchronous) clears all valid bits and the row sequencer.
// The receiver cannot stall, so the pipeline never stops.
module look_at_matrix_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	output logic               result_strobe,
	output logic [1:0]         row_index,
	output logic signed [31:0] col0,
	output logic signed [31:0] col1,
	output logic signed [31:0] col2,
	output logic signed [31:0] col3,
	output logic               degenerate,
	output logic               last_row
);

	localparam int UW = lam_pkg::UNIT_W;
	localparam int FWD_DLY = lam_pkg::PROJ_LAT + lam_pkg::NORM_LAT;
	localparam int EYE_DLY = 2 * lam_pkg::NORM_LAT + lam_pkg::PROJ_LAT
		+ lam_pkg::CROSS_LAT;

	// Rows leave one per cycle, so after each transfer busy holds off the next one until
	// all four rows of a matrix can leave. With a fixed latency this also guarantees that
	// matrices never overlap at the output.
	logic [1:0] cool_q;
	logic       take;

	assign busy = (cool_q != 2'd0);
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cool_q <= '0;
		end else if (take) begin
			cool_q <= 2'd3;
		end else if (busy) begin
			cool_q <= cool_q - 2'd1;
		end
	end

	// First stage: the forward difference at full width, and the eye.
	logic          vld_s1;
	lam_pkg::vec_t d_s1 [3];
	logic [95:0]   eye_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		d_s1[0] <= lam_pkg::VEC_W'(target_x) - lam_pkg::VEC_W'(eye_x);
		d_s1[1] <= lam_pkg::VEC_W'(target_y) - lam_pkg::VEC_W'(eye_y);
		d_s1[2] <= lam_pkg::VEC_W'(target_z) - lam_pkg::VEC_W'(eye_z);
		eye_s1  <= {eye_x, eye_y, eye_z};
	end

	// Forward direction.
	lam_pkg::norm_ctl_t fwd_ctl;
	lam_pkg::unit_t     fwd [3];

	lam_norm u_norm_fwd (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(vld_s1),
		.in_vec  (d_s1),
		.out_ctl (fwd_ctl),
		.out_vec (fwd)
	);

	// World up with its forward component removed.
	logic          pre_valid;
	lam_pkg::vec_t pre [3];

	lam_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fwd_ctl.valid),
		.fwd      (fwd),
		.out_valid(pre_valid),
		.pre      (pre)
	);

	lam_pkg::norm_ctl_t nup_ctl;
	lam_pkg::unit_t     nup [3];

	lam_norm u_norm_up (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pre_valid),
		.in_vec  (pre),
		.out_ctl (nup_ctl),
		.out_vec (nup)
	);

	// Forward and its flag wait for the new up.
	logic [3*UW:0]  fwd_dly;
	lam_pkg::unit_t fwd_al [3];
	logic           ok_f_al;

	lam_delay #(
		.WIDTH(3 * UW + 1),
		.DEPTH(FWD_DLY)
	) u_fwd_dly (
		.clk (clk),
		.din ({fwd_ctl.ok, fwd[0], fwd[1], fwd[2]}),
		.dout(fwd_dly)
	);

	assign ok_f_al   = fwd_dly[3*UW];
	assign fwd_al[0] = fwd_dly[3*UW-1:2*UW];
	assign fwd_al[1] = fwd_dly[2*UW-1:UW];
	assign fwd_al[2] = fwd_dly[UW-1:0];

	// Right = new up x forward.
	logic           row_valid;
	logic           row_degen;
	logic [31:0]    rgt [3];
	lam_pkg::unit_t nup_row [3];
	lam_pkg::unit_t fwd_row [3];

	lam_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nup_ctl.valid),
		.in_degen (!(ok_f_al && nup_ctl.ok)),
		.nup      (nup),
		.fwd      (fwd_al),
		.out_valid(row_valid),
		.out_degen(row_degen),
		.rgt      (rgt),
		.nup_out  (nup_row),
		.fwd_out  (fwd_row)
	);

	// The eye passes through unchanged to the last row.
	logic [95:0] eye_al;

	lam_delay #(
		.WIDTH(96),
		.DEPTH(EYE_DLY)
	) u_eye_dly (
		.clk (clk),
		.din (eye_s1),
		.dout(eye_al)
	);

	// Row sequencer: a finished matrix is held and sent as four transfers.
	logic           act_q;
	logic [1:0]     idx_q;
	logic [31:0]    rgt_q [3];
	lam_pkg::unit_t nup_q [3];
	lam_pkg::unit_t fwd_q [3];
	logic [95:0]    eye_q;
	logic           degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (row_valid) begin
			act_q <= 1'b1;
			idx_q <= '0;
		end else if (act_q) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				act_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (row_valid) begin
			rgt_q   <= rgt;
			nup_q   <= nup_row;
			fwd_q   <= fwd_row;
			eye_q   <= eye_al;
			degen_q <= row_degen;
		end
	end

	always_comb begin
		col3 = '0;
		case (idx_q)
			2'd0: begin
				col0 = signed'(rgt_q[0]);
				col1 = signed'(rgt_q[1]);
				col2 = signed'(rgt_q[2]);
			end
			2'd1: begin
				col0 = 32'(nup_q[0]);
				col1 = 32'(nup_q[1]);
				col2 = 32'(nup_q[2]);
			end
			2'd2: begin
				col0 = 32'(fwd_q[0]);
				col1 = 32'(fwd_q[1]);
				col2 = 32'(fwd_q[2]);
			end
			default: begin
				col0 = signed'(eye_q[95:64]);
				col1 = signed'(eye_q[63:32]);
				col2 = signed'(eye_q[31:0]);
				col3 = signed'(lam_pkg::FX_ONE);
			end
		endcase
	end

	assign result_strobe = act_q;
	assign row_index     = idx_q;
	assign degenerate    = degen_q;
	assign last_row      = (idx_q == 2'd3);

endmodule

>>> bench/look_at_matrix_builder_tb.sv
module look_at_matrix_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// One expected matrix row, held until the block emits it.
	typedef struct {
		logic [1:0]  idx;
		logic [31:0] c0;
		logic [31:0] c1;
		logic [31:0] c2;
		logic [31:0] c3;
		logic        degen;
		logic        last;
	} row_t;

	localparam int ROW_LATENCY = 2 * lam_pkg::NORM_LAT + 5;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [31:0] eye_x = '0;
	logic signed [31:0] eye_y = '0;
	logic signed [31:0] eye_z = '0;
	logic signed [31:0] target_x = '0;
	logic signed [31:0] target_y = '0;
	logic signed [31:0] target_z = '0;
	logic               result_strobe;
	logic [1:0]         row_index;
	logic signed [31:0] col0;
	logic signed [31:0] col1;
	logic signed [31:0] col2;
	logic signed [31:0] col3;
	logic               degenerate;
	logic               last_row;

	row_t pending_rows[$];
	int   error_count = 0;
	int   burst_left = 0;

	look_at_matrix_builder u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.result_strobe(result_strobe), .row_index(row_index),
		.col0(col0), .col1(col1), .col2(col2), .col3(col3),
		.degenerate(degenerate), .last_row(last_row)
	);

	always #10 clk = ~clk;

	// Prints one line per mismatch and counts it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		error_count++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// Integer square root, one result bit per step, on 64-bit operands.
	function automatic logic [63:0] int_sqrt(input logic [63:0] num);
		logic [63:0] res;
		logic [63:0] bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > num) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (num >= res + bit_v) begin
				num = num - (res + bit_v);
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	// Product rescaled to Q16.16, rounding to nearest with ties away from zero.
	function automatic longint q16_round(input longint v);
		longint unsigned mag;
		longint unsigned r;
		mag = (v < 0) ? -v : v;
		r = (mag + 64'h8000) >> 16;
		return (v < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// Scales the vector so its largest magnitude tops out at bit 30, then
	// divides each component by the rounded-down length. Returns 0 on zero.
	function automatic bit unit_vector(input longint v[3], output longint u[3]);
		longint unsigned mag[3];
		bit neg[3];
		longint unsigned mx, sum, len, q;
		int top;
		mx = 0; sum = 0; top = -1;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? -v[i] : v[i];
			if (mag[i] > mx) mx = mag[i];
			u[i] = 0;
		end
		if (mx == 0) return 0;
		for (int i = 0; i < 64; i++) if (mx[i]) top = i;
		for (int i = 0; i < 3; i++) begin
			if (top > 30) mag[i] = mag[i] >> (top - 30);
			else mag[i] = mag[i] << (30 - top);
			sum += mag[i] * mag[i];
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * 65536 + (len >> 1)) / len;
			u[i] = neg[i] ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	// Builds the four rows of the look-at matrix for one eye and target.
	task automatic predict_matrix(input logic signed [31:0] e[3],
			input logic signed [31:0] t[3]);
		longint d[3], fwd[3], pre[3], nup[3], rgt[3];
		longint m[4][4];
		bit ok_f, ok_u;
		row_t r;
		for (int i = 0; i < 3; i++) d[i] = longint'(t[i]) - longint'(e[i]);
		ok_f = unit_vector(d, fwd);
		pre[0] = -q16_round(fwd[0] * fwd[1]);
		pre[1] = 65536 - q16_round(fwd[1] * fwd[1]);
		pre[2] = -q16_round(fwd[2] * fwd[1]);
		ok_u = unit_vector(pre, nup);
		rgt[0] = q16_round(nup[1] * fwd[2] - nup[2] * fwd[1]);
		rgt[1] = q16_round(nup[2] * fwd[0] - nup[0] * fwd[2]);
		rgt[2] = q16_round(nup[0] * fwd[1] - nup[1] * fwd[0]);
		for (int i = 0; i < 3; i++) begin
			m[0][i] = rgt[i];
			m[1][i] = nup[i];
			m[2][i] = fwd[i];
			m[3][i] = e[i];
		end
		m[0][3] = 0; m[1][3] = 0; m[2][3] = 0; m[3][3] = 65536;
		for (int k = 0; k < 4; k++) begin
			r.idx = 2'(k);
			r.c0 = clamp32(m[k][0]);
			r.c1 = clamp32(m[k][1]);
			r.c2 = clamp32(m[k][2]);
			r.c3 = clamp32(m[k][3]);
			r.degen = !(ok_f && ok_u);
			r.last = (k == 3);
			pending_rows.push_back(r);
		end
	endtask

	// Sends one item. The sender works in bursts; between bursts it leaves
	// a random gap so that pauses land on every phase of the row sequencer.
	task automatic send_view(input logic signed [31:0] e[3],
			input logic signed [31:0] t[3]);
		logic signed [31:0] ec[3];
		logic signed [31:0] tc[3];
		int gap;
		ec = e;
		tc = t;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 9);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		eye_x <= ec[0]; eye_y <= ec[1]; eye_z <= ec[2];
		target_x <= tc[0]; target_y <= tc[1]; target_z <= tc[2];
		start <= 1'b1;
		// The transfer happens at the first rising edge with busy low.
		do @(posedge clk); while (busy);
		predict_matrix(ec, tc);
		// Busy is high after the transfer, so start may stay high
		// until the next call either lowers it or brings a new item.
		@(negedge clk);
	endtask

	// Every strobed row is checked against the oldest expected row.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (pending_rows.size() == 0) begin
				report_mismatch("row with nothing expected", {30'b0, row_index}, 32'hx);
			end else begin
				row_t w;
				w = pending_rows.pop_front();
				if (row_index !== w.idx)
					report_mismatch("row_index", 32'(row_index), 32'(w.idx));
				if (col0 !== w.c0) report_mismatch("col0", col0, w.c0);
				if (col1 !== w.c1) report_mismatch("col1", col1, w.c1);
				if (col2 !== w.c2) report_mismatch("col2", col2, w.c2);
				if (col3 !== w.c3) report_mismatch("col3", col3, w.c3);
				if (degenerate !== w.degen)
					report_mismatch("degenerate", 32'(degenerate), 32'(w.degen));
				if (last_row !== w.last)
					report_mismatch("last_row", 32'(last_row), 32'(w.last));
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 15) << 16;
			3: return -($urandom_range(0, 15) << 16);
			default: return $urandom;
		endcase
	endfunction

	// Eye equals target, forward along world up and extreme coordinates.
	task automatic test_special_cases();
		logic signed [31:0] e[3];
		logic signed [31:0] t[3];
		e = '{0, 0, 0}; t = '{0, 0, 0}; send_view(e, t);
		e = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678}; t = e; send_view(e, t);
		e = '{0, 0, 0}; t = '{0, 32'h0001_0000, 0}; send_view(e, t);
		e = '{5, 32'h7FFF_FFFF, -7}; t = '{5, 32'h8000_0000, -7}; send_view(e, t);
		// Nearly parallel to world up, leaving a small residue.
		e = '{0, 0, 0}; t = '{1, 32'h7FFF_FFFF, 0}; send_view(e, t);
		e = '{0, 0, 0}; t = '{32'h0001_0000, 0, 0}; send_view(e, t);
		e = '{0, 0, 0}; t = '{0, 0, 32'hFFFF_0000}; send_view(e, t);
		e = '{0, 0, 32'h0005_0000}; t = '{0, 0, 0}; send_view(e, t);
		// Extreme differences in every axis.
		e = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		t = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}; send_view(e, t);
		send_view(t, e);
		e = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
		t = '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001}; send_view(e, t);
		e = '{32'h0003_0000, 32'h0002_0000, 32'h0001_0000};
		t = '{32'hFFFD_0000, 32'h0004_0000, 32'h0009_0000}; send_view(e, t);
	endtask

	// Random eyes and targets, with some repeats of the degenerate shapes.
	task automatic test_random_views(input int count);
		logic signed [31:0] e[3];
		logic signed [31:0] t[3];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 3; i++) begin
				e[i] = rand_word();
				t[i] = rand_word();
			end
			case ($urandom_range(0, 9))
				0: t = e;
				1: begin t[0] = e[0]; t[2] = e[2]; end
				default: ;
			endcase
			send_view(e, t);
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_special_cases();
		test_random_views(150);
		start <= 1'b0;
		burst_left = 0;
		// Drain the pipeline, then allow a little extra for stray rows.
		while (pending_rows.size() != 0) @(posedge clk);
		repeat (ROW_LATENCY + 10) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
